FILE: hdl/sector_free_stack_allocator_unit_defines.svh
// Assertion helpers shared by the allocator RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef SECTOR_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define SECTOR_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define SFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfsa: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfsa: next-cycle check failed");

`endif

FILE: hdl/sfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfsa_pkg;

    localparam int SECTOR_CAPACITY = 4096;
    localparam int ADDR_W          = $clog2(SECTOR_CAPACITY);
    localparam int SEC_W           = 12;
    localparam int CNT_W           = 13;
    localparam int SIZE_W          = 13;

    typedef enum logic [1:0] {
        CMD_MARK_USED   = 2'd0,
        CMD_MARK_UNUSED = 2'd1,
        CMD_QUERY_USED  = 2'd2,
        CMD_NEXT_FREE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_ALREADY_USED   = 3'd1,
        ST_NOT_EXPECTED   = 3'd2,
        ST_ALREADY_UNUSED = 3'd3,
        ST_FULL           = 3'd4,
        ST_RANGE          = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/sfsa_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one beat carries one command.
interface sfsa_cmd_if
    import sfsa_pkg::*;
();
    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [SEC_W-1:0] sector;

    modport source (output valid, command, sector, input ready);
    modport sink   (input valid, command, sector, output ready);
endinterface

// Response channel: one beat per command.
interface sfsa_rsp_if
    import sfsa_pkg::*;
();
    logic             valid;
    logic             ready;
    t_status          status;
    logic             is_used;
    logic [SEC_W-1:0] free_sector;
    logic [CNT_W-1:0] count_used;

    modport source (output valid, status, is_used, free_sector, count_used, input ready);
    modport sink   (input valid, status, is_used, free_sector, count_used, output ready);
endinterface

`default_nettype wire

FILE: hdl/sector_free_stack_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Handshake          Beat contents
// i_cmd       in   valid / ready      command, sector
// o_rsp       out  valid / ready      status, is_used, free_sector, count_used
// i_cfg_*     in   write enable only  disk_size (13 bits)
//
// The beat of a command is accepted while both RAMs are read, and in the
// following cycle the result is formed, the RAMs are written back and the
// response register is loaded. The stack RAM's single read-modify-write per
// command, at the address the previous command left, is why commands do not overlap.
// After reset a clearing pass loads entry i of the stack with i and clears the
// used bitmap; no command is accepted during it.
// A command is accepted only when the response register is empty or drains in
// the same cycle, so a stalled response holds back the next command.

module sector_free_stack_allocator_unit
    import sfsa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sfsa_cmd_if.sink               i_cmd,
    sfsa_rsp_if.source             o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata
);

`include "sector_free_stack_allocator_unit_defines.svh"

    // Control and configuration registers.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [SIZE_W-1:0]   r_disk_size;
    logic [CNT_W-1:0]    r_used_total, n_used_total;

    // The command being executed.
    t_cmd                r_cmd;
    logic [SEC_W-1:0]    r_sector;

    // Response register.
    logic                r_out_valid;
    t_status             r_status;
    logic                r_is_used;
    logic [SEC_W-1:0]    r_free_sector;
    logic [CNT_W-1:0]    r_count_used;

    // RAM ports.
    logic                w_stack_we;
    logic [ADDR_W-1:0]   w_stack_waddr;
    logic [SEC_W-1:0]    w_stack_wdata;
    logic [SEC_W-1:0]    w_stack_q;
    logic                w_map_we;
    logic [ADDR_W-1:0]   w_map_waddr;
    logic                w_map_wdata;
    logic                w_map_q;

    // Execution results.
    logic                w_accept;
    logic [CNT_W-1:0]    w_size;
    logic                w_full;
    logic                w_in_range;
    t_status             w_status;
    logic                w_is_used;
    logic [SEC_W-1:0]    w_free_sector;
    logic                w_do_mark;
    logic                w_do_unmark;

    // A command enters only in IDLE and only when the response slot will be free
    // by the time its result is ready.
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // The effective disk size is capped at the RAM depth.
    assign w_size     = (r_disk_size > SIZE_W'(SECTOR_CAPACITY)) ? CNT_W'(SECTOR_CAPACITY)
                                                                 : CNT_W'(r_disk_size);
    assign w_full     = (r_used_total >= w_size);
    assign w_in_range = ({1'b0, r_sector} < w_size);

    // The stack RAM is read at the current count, which is also the stack
    // pointer; the bitmap is read at the incoming sector. Writes happen in
    // EXEC, and the next read comes only after a return to IDLE, so the read always
    // sees the updated contents.
    sfsa_ram #(
        .DEPTH (SECTOR_CAPACITY),
        .WIDTH (SEC_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stack_we),
        .i_waddr (w_stack_waddr),
        .i_wdata (w_stack_wdata),
        .i_re    (w_accept),
        .i_raddr (r_used_total[ADDR_W-1:0]),
        .o_rdata (w_stack_q)
    );

    sfsa_ram #(
        .DEPTH (SECTOR_CAPACITY),
        .WIDTH (1)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_re    (w_accept),
        .i_raddr (i_cmd.sector[ADDR_W-1:0]),
        .o_rdata (w_map_q)
    );

    // Command evaluation, valid during EXEC when the RAM data has arrived.
    always_comb begin
        w_status      = ST_OK;
        w_is_used     = 1'b0;
        w_free_sector = '0;
        w_do_mark     = 1'b0;
        w_do_unmark   = 1'b0;
        unique case (r_cmd)
            CMD_NEXT_FREE: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_free_sector = w_stack_q;
                end
            end
            CMD_MARK_USED: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else if (w_map_q) begin
                    w_status = ST_ALREADY_USED;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_stack_q != r_sector) begin
                    w_status = ST_NOT_EXPECTED;
                end else begin
                    w_do_mark = 1'b1;
                end
            end
            CMD_MARK_UNUSED: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else if (!w_map_q || (r_used_total == '0)) begin
                    w_status = ST_ALREADY_UNUSED;
                end else begin
                    w_do_unmark = 1'b1;
                end
            end
            CMD_QUERY_USED: begin
                if (!w_in_range) begin
                    w_status = ST_RANGE;
                end else begin
                    w_is_used = w_map_q;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // New count: a successful mark pushes the pointer up, an unmark pops it.
    always_comb begin
        n_used_total = r_used_total;
        if (r_state == S_EXEC) begin
            if (w_do_mark) begin
                n_used_total = r_used_total + CNT_W'(1);
            end else if (w_do_unmark) begin
                n_used_total = r_used_total - CNT_W'(1);
            end
        end
    end

    // RAM write ports: the clearing pass, or the write-back of EXEC.
    always_comb begin
        w_stack_we    = 1'b0;
        w_stack_waddr = r_clr;
        w_stack_wdata = SEC_W'(r_clr);
        w_map_we      = 1'b0;
        w_map_waddr   = r_clr;
        w_map_wdata   = 1'b0;
        if (r_state == S_CLEAR) begin
            w_stack_we = 1'b1;
            w_map_we   = 1'b1;
        end else if (r_state == S_EXEC) begin
            // Unmark stores the sector at the new top, one below the old count.
            w_stack_we    = w_do_unmark;
            w_stack_waddr = n_used_total[ADDR_W-1:0];
            w_stack_wdata = r_sector;
            w_map_we      = w_do_mark || w_do_unmark;
            w_map_waddr   = r_sector[ADDR_W-1:0];
            w_map_wdata   = w_do_mark;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_disk_size  <= SIZE_W'(4096);
            r_used_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used_total <= n_used_total;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_disk_size <= i_cfg_wdata;
            end
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd.command;
            r_sector <= i_cmd.sector;
        end
        if (r_state == S_EXEC) begin
            r_status      <= w_status;
            r_is_used     <= w_is_used;
            r_free_sector <= w_free_sector;
            r_count_used  <= n_used_total;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.is_used     = r_is_used;
    assign o_rsp.free_sector = r_free_sector;
    assign o_rsp.count_used  = r_count_used;

    `SFSA_ASSERT_NOW(a_count_bound, 1'b1, r_used_total <= CNT_W'(SECTOR_CAPACITY))
    `SFSA_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC)
    `SFSA_ASSERT_NEXT(a_exec_response, r_state == S_EXEC, r_out_valid)
    `SFSA_ASSERT_NEXT(a_count_only_exec, r_state != S_EXEC, $stable(r_used_total))
    `SFSA_ASSERT_NOW(a_clear_quiet, r_state == S_CLEAR, !r_out_valid)

endmodule

`default_nettype wire

FILE: hdl/sfsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module sfsa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
